/* rtl/array_double_ended_queue_core_assert.svh */
// Assertion macros for the array deque core.
// Used by array_double_ended_queue_core; expects clk and rst_n in scope.
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define ADQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adq assertion failed");

// next-cycle implication
`define ADQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adq assertion failed");

`endif

/* rtl/adq_pkg.sv */
// Package for the array deque core: sizes, operation and status codes,
// controller states and the command struct. No dependencies.
`timescale 1ns / 1ps

package adq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REAR_FULL = 2'd1,
        ST_NO_FRONT  = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

/* rtl/adq_ctrl.sv */
// Controller for the array deque core: sequences capture, execute and
// result hold. Depends on adq_pkg.
`timescale 1ns / 1ps

module adq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output adq_pkg::cmd_t  cmd
);

    adq_pkg::state_t state_reg;
    adq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= adq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            adq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = adq_pkg::S_EXEC;
                end
            end
            adq_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = adq_pkg::S_DONE;
            end
            adq_pkg::S_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = adq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = adq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/adq_dpath.sv */
// Datapath for the array deque core: operand registers, head/tail pointers,
// storage array and result registers. Depends on adq_pkg.
`timescale 1ns / 1ps

module adq_dpath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  adq_pkg::cmd_t                      cmd,
    input  logic [1:0]                         mode,
    input  logic signed [adq_pkg::DATA_W-1:0]  push_value,
    output logic signed [adq_pkg::DATA_W-1:0]  pop_value,
    output logic [1:0]                         status
);

    localparam logic [adq_pkg::PTR_W-1:0] PTR_DEPTH = adq_pkg::PTR_W'(adq_pkg::DEPTH);
    localparam logic [adq_pkg::PTR_W-1:0] PTR_ONE   = adq_pkg::PTR_W'(1);

    adq_pkg::mode_t                op_reg;
    logic [adq_pkg::DATA_W-1:0]    val_reg;
    logic [adq_pkg::PTR_W-1:0]     head_reg;
    logic [adq_pkg::PTR_W-1:0]     head_next;
    logic [adq_pkg::PTR_W-1:0]     tail_reg;
    logic [adq_pkg::PTR_W-1:0]     tail_next;
    adq_pkg::status_t              status_reg;
    adq_pkg::status_t              status_next;
    logic                          pop_ok_reg;
    logic                          pop_ok_next;
    logic [adq_pkg::DATA_W-1:0]    rd_data_reg;

    logic [adq_pkg::DATA_W-1:0]    mem [adq_pkg::DEPTH];
    logic                          wr_en;
    logic                          rd_en;
    logic [adq_pkg::IDX_W-1:0]     wr_addr;
    logic [adq_pkg::IDX_W-1:0]     rd_addr;
    logic [adq_pkg::PTR_W-1:0]     head_dec;
    logic [adq_pkg::PTR_W-1:0]     tail_dec;
    logic                          empty;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= adq_pkg::mode_t'(mode);
            val_reg <= push_value;
        end
    end

    assign empty    = (head_reg == tail_reg);
    assign head_dec = head_reg - PTR_ONE;
    assign tail_dec = tail_reg - PTR_ONE;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        status_next = adq_pkg::ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = tail_reg[adq_pkg::IDX_W-1:0];
        rd_addr     = head_reg[adq_pkg::IDX_W-1:0];
        case (op_reg)
            adq_pkg::MODE_PUSH_REAR:
            begin
                if (tail_reg >= PTR_DEPTH)
                begin
                    status_next = adq_pkg::ST_REAR_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    tail_next = tail_reg + PTR_ONE;
                end
            end
            adq_pkg::MODE_PUSH_FRONT:
            begin
                wr_addr = head_dec[adq_pkg::IDX_W-1:0];
                if (head_reg == '0)
                begin
                    status_next = adq_pkg::ST_NO_FRONT;
                end
                else
                begin
                    wr_en     = 1'b1;
                    head_next = head_dec;
                end
            end
            adq_pkg::MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = adq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    pop_ok_next = 1'b1;
                    head_next   = head_reg + PTR_ONE;
                end
            end
            default:
            begin
                rd_addr = tail_dec[adq_pkg::IDX_W-1:0];
                if (empty)
                begin
                    status_next = adq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    pop_ok_next = 1'b1;
                    tail_next   = tail_dec;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign pop_value = pop_ok_reg ? rd_data_reg : '0;
    assign status    = status_reg;

endmodule

/* rtl/array_double_ended_queue_core.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | mode, push_value
// out     | output    | out_valid/out_stall| pop_value, status
//
// Each transaction runs through capture, one storage access with pointer update,
// then the result held with out_valid high until out_stall is low.
// out_valid rises once the controller steps from S_EXEC into S_DONE, and the
// result is taken when out_valid is high and out_stall is low.
// Reset clears head and tail pointers; storage is not cleared.
// A new transaction is taken only after the previous result is accepted.
// Top level of the array deque core; uses adq_pkg, adq_ctrl, adq_dpath.
`timescale 1ns / 1ps
`include "array_double_ended_queue_core_assert.svh"

module array_double_ended_queue_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic signed [adq_pkg::DATA_W-1:0] push_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [adq_pkg::DATA_W-1:0] pop_value,
    output logic [1:0]                        status
);

    adq_pkg::cmd_t cmd;

    adq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    adq_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mode       (mode),
        .push_value (push_value),
        .pop_value  (pop_value),
        .status     (status)
    );

    `ADQ_ASSERT_NOW(a_one_in_flight, out_valid, in_stall)
    `ADQ_ASSERT_NEXT(a_accept_no_result, in_valid && !in_stall, !out_valid && in_stall)
    `ADQ_ASSERT_NOW(a_value_needs_ok, out_valid && (pop_value != '0), status == adq_pkg::ST_OK)

endmodule
